// ----- rtl/core/frt_pkg.sv -----
// Shared types and constants of the fragment reassembly tracker.
// Used by frt_front, frt_back and fragment_reassembly_tracker; depends on nothing.
`timescale 1ns / 1ps

package frt_pkg;

    localparam int SLOT_COUNT_DEF    = 1024;
    localparam int MAX_FRAGMENTS_DEF = 64;
    localparam int LENGTH_BITS_DEF   = 16;

    localparam int CMD_W    = 3;
    localparam int TIME_W   = 32;
    localparam int SLOT_W   = 10;
    localparam int LEN_W    = 16;
    localparam int FCNT_W   = 7;
    localparam int FIDX_W   = 6;
    localparam int STATUS_W = 3;

    localparam logic [CMD_W-1:0] CMD_ALLOC     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADD       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TAKE      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RELEASE   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ_TIME = 3'd5;

    localparam logic [STATUS_W-1:0] STS_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STS_NO_FREE    = 3'd1;
    localparam logic [STATUS_W-1:0] STS_INCOMPLETE = 3'd2;
    localparam logic [STATUS_W-1:0] STS_BAD_STATE  = 3'd3;
    localparam logic [STATUS_W-1:0] STS_BAD_INDEX  = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [TIME_W-1:0] current_time;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  total_length;
        logic [FCNT_W-1:0] fragment_count;
        logic [FIDX_W-1:0] fragment_index;
        logic [LEN_W-1:0]  fragment_length;
        logic              slot_ok;
        logic              count_ok;
    } cmd_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_out;
        logic [TIME_W-1:0]   timestamp;
        logic [LEN_W-1:0]    received_length;
        logic [LEN_W-1:0]    message_length;
    } result_t;

endpackage

// ----- rtl/core/frt_front.sv -----
// Front end: accepts requests, checks slot range and fragment count, and queues them.
// Depends on frt_pkg.
`timescale 1ns / 1ps

module frt_front #(
    parameter int SLOT_COUNT    = frt_pkg::SLOT_COUNT_DEF,
    parameter int MAX_FRAGMENTS = frt_pkg::MAX_FRAGMENTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  frt_pkg::cmd_req_t in_req,
    output logic              q_valid,
    input  logic              q_pop,
    output frt_pkg::cmd_req_t q_req
);
    import frt_pkg::*;

    cmd_req_t    queue_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        pop;
    cmd_req_t    classified;

    always_comb
    begin
        classified          = in_req;
        classified.slot_ok  = (32'(in_req.slot) < SLOT_COUNT);
        classified.count_ok = (32'(in_req.fragment_count) <= MAX_FRAGMENTS);
    end

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_req    = queue_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= classified;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/core/frt_back.sv -----
// Back end: slot context memory, free list memory, command execution and result register.
// Depends on frt_pkg.
`timescale 1ns / 1ps

module frt_back #(
    parameter int SLOT_COUNT    = frt_pkg::SLOT_COUNT_DEF,
    parameter int MAX_FRAGMENTS = frt_pkg::MAX_FRAGMENTS_DEF,
    parameter int LENGTH_BITS   = frt_pkg::LENGTH_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_pop,
    input  frt_pkg::cmd_req_t q_req,
    output logic              out_valid,
    input  logic              out_ready,
    output frt_pkg::result_t  out_res
);
    import frt_pkg::*;

    localparam int SLOT_BITS = $clog2(SLOT_COUNT);
    localparam int SUM_W     = ((LENGTH_BITS > LEN_W) ? LENGTH_BITS : LEN_W) + 1;

    typedef struct packed {
        logic                     allocated;
        logic                     active;
        logic [LENGTH_BITS-1:0]   total;
        logic [FCNT_W-1:0]        fragments;
        logic [LENGTH_BITS-1:0]   counted;
        logic [MAX_FRAGMENTS-1:0] seen;
        logic [TIME_W-1:0]        last;
    } entry_t;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_FIFO, S_EXEC} state_t;

    entry_t               ctx_mem [SLOT_COUNT];
    logic [SLOT_BITS-1:0] free_mem [SLOT_COUNT];

    state_t               state_reg;
    cmd_req_t             cur_reg;
    logic [SLOT_BITS-1:0] head_reg;
    logic [SLOT_BITS-1:0] tail_reg;
    logic [SLOT_BITS:0]   count_reg;
    logic [SLOT_BITS-1:0] clr_reg;
    logic                 out_valid_reg;
    result_t              out_reg;

    entry_t               rd_q;
    logic [SLOT_BITS-1:0] fifo_q;
    logic                 rd_en;
    logic [SLOT_BITS-1:0] rd_addr;
    logic                 commit;
    logic [SLOT_BITS-1:0] exec_idx;
    entry_t               ent_new;
    logic                 ent_write;
    logic                 report;
    logic                 take_ok;
    logic                 do_alloc;
    logic                 do_release;
    logic [STATUS_W-1:0]  status;
    logic [SLOT_W-1:0]    slot_out;
    logic [SUM_W-1:0]     sum;
    logic [MAX_FRAGMENTS-1:0] bit_mask;
    result_t              res;
    logic                 mem_we;
    logic [SLOT_BITS-1:0] mem_waddr;
    entry_t               mem_wdata;

    function automatic logic [SLOT_BITS-1:0] ring_next(input logic [SLOT_BITS-1:0] p);
        ring_next = (p == SLOT_BITS'(SLOT_COUNT - 1)) ? '0 : p + 1'b1;
    endfunction

    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign rd_en     = q_pop || (state_reg == S_FIFO);
    assign rd_addr   = (state_reg == S_FIFO) ? fifo_q : SLOT_BITS'(q_req.slot);
    assign commit    = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    always_comb
    begin
        exec_idx   = (cur_reg.command == CMD_ALLOC) ? fifo_q : SLOT_BITS'(cur_reg.slot);
        ent_new    = rd_q;
        ent_write  = 1'b0;
        report     = 1'b1;
        take_ok    = 1'b0;
        do_alloc   = 1'b0;
        do_release = 1'b0;
        status     = STS_OK;
        slot_out   = cur_reg.slot;
        sum        = SUM_W'(rd_q.counted) + SUM_W'(cur_reg.fragment_length);
        bit_mask   = MAX_FRAGMENTS'(1) << cur_reg.fragment_index;
        if (cur_reg.command == CMD_ALLOC)
        begin
            if (count_reg == '0)
            begin
                status   = STS_NO_FREE;
                slot_out = '0;
                report   = 1'b0;
            end
            else
            begin
                slot_out          = SLOT_W'(fifo_q);
                ent_new.allocated = 1'b1;
                ent_write         = 1'b1;
                do_alloc          = 1'b1;
            end
        end
        else if (!cur_reg.slot_ok)
        begin
            status = STS_BAD_STATE;
            report = 1'b0;
        end
        else
        begin
            case (cur_reg.command)
                CMD_START:
                begin
                    if (!rd_q.allocated)
                    begin
                        status = STS_BAD_STATE;
                    end
                    else if (!cur_reg.count_ok)
                    begin
                        status = STS_BAD_INDEX;
                    end
                    else
                    begin
                        ent_new.active    = 1'b1;
                        ent_new.total     = LENGTH_BITS'(cur_reg.total_length);
                        ent_new.fragments = cur_reg.fragment_count;
                        ent_new.counted   = '0;
                        ent_new.seen      = '0;
                        ent_new.last      = cur_reg.current_time;
                        ent_write         = 1'b1;
                    end
                end
                CMD_ADD:
                begin
                    if (!rd_q.allocated || !rd_q.active)
                    begin
                        status = STS_BAD_STATE;
                    end
                    else if (FCNT_W'(cur_reg.fragment_index) >= rd_q.fragments)
                    begin
                        status = STS_BAD_INDEX;
                    end
                    else
                    begin
                        if ((rd_q.seen & bit_mask) == '0)
                        begin
                            ent_new.counted = (sum > SUM_W'({LENGTH_BITS{1'b1}}))
                                            ? {LENGTH_BITS{1'b1}} : LENGTH_BITS'(sum);
                            ent_new.seen    = rd_q.seen | bit_mask;
                        end
                        ent_new.last = cur_reg.current_time;
                        ent_write    = 1'b1;
                    end
                end
                CMD_TAKE:
                begin
                    if (!rd_q.allocated || !rd_q.active)
                    begin
                        status = STS_BAD_STATE;
                    end
                    else if (rd_q.counted != rd_q.total)
                    begin
                        status = STS_INCOMPLETE;
                    end
                    else
                    begin
                        take_ok           = 1'b1;
                        ent_new.active    = 1'b0;
                        ent_new.total     = '0;
                        ent_new.fragments = '0;
                        ent_new.counted   = '0;
                        ent_new.seen      = '0;
                        ent_write         = 1'b1;
                    end
                end
                CMD_RELEASE:
                begin
                    if (!rd_q.allocated || (count_reg >= (SLOT_BITS+1)'(SLOT_COUNT)))
                    begin
                        status = STS_BAD_STATE;
                    end
                    else
                    begin
                        ent_new.allocated = 1'b0;
                        ent_new.active    = 1'b0;
                        ent_new.total     = '0;
                        ent_new.fragments = '0;
                        ent_new.counted   = '0;
                        ent_new.seen      = '0;
                        ent_write         = 1'b1;
                        do_release        = 1'b1;
                    end
                end
                CMD_READ_TIME:
                begin
                    status = STS_OK;
                end
                default:
                begin
                    status = STS_BAD_STATE;
                end
            endcase
        end

        res.status          = status;
        res.slot_out        = slot_out;
        res.timestamp       = report ? ent_new.last : '0;
        res.received_length = !report ? '0
                            : (take_ok ? LEN_W'(rd_q.counted) : LEN_W'(ent_new.counted));
        res.message_length  = take_ok ? LEN_W'(rd_q.total) : '0;

        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = commit && ent_write;
            mem_waddr = exec_idx;
            mem_wdata = ent_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ctx_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_q <= ctx_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            free_mem[clr_reg] <= clr_reg;
        end
        else if (commit && do_release)
        begin
            free_mem[tail_reg] <= exec_idx;
        end
        if (q_pop)
        begin
            fifo_q <= free_mem[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cur_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= (SLOT_BITS+1)'(SLOT_COUNT);
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (commit)
            begin
                out_reg       <= res;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == SLOT_BITS'(SLOT_COUNT - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cur_reg <= q_req;
                        if ((q_req.command == CMD_ALLOC) && (count_reg != '0))
                        begin
                            state_reg <= S_FIFO;
                        end
                        else
                        begin
                            state_reg <= S_EXEC;
                        end
                    end
                end
                S_FIFO:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    if (commit)
                    begin
                        state_reg <= S_IDLE;
                        if (do_alloc)
                        begin
                            head_reg  <= ring_next(head_reg);
                            count_reg <= count_reg - 1'b1;
                        end
                        if (do_release)
                        begin
                            tail_reg  <= ring_next(tail_reg);
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/fragment_reassembly_tracker.sv -----
// Top level of the fragment reassembly tracker: stream ports, front end and back end.
// Depends on frt_pkg, frt_front and frt_back.
//
//  Channel  Direction  Carries
//  s_*      in         one command request per handshake, command in s_tuser
//  m_*      out        one result request per command, status in m_tuser
//
// In the back end a command reads the slot memory, then updates it and writes the result
// register; allocate first reads the free list memory, then the slot memory.
// After reset the back end clears the slot memory and fills the free list with every slot
// number; requests queue meanwhile. A two-entry queue between front and back holds up to
// two requests while the back end is busy or the result register waits on m_tready.
`timescale 1ns / 1ps

module fragment_reassembly_tracker #(
    parameter int SLOT_COUNT    = frt_pkg::SLOT_COUNT_DEF,
    parameter int MAX_FRAGMENTS = frt_pkg::MAX_FRAGMENTS_DEF,
    parameter int LENGTH_BITS   = frt_pkg::LENGTH_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // current_time[31:0], slot[41:32], total_length[57:42], fragment_count[64:58],
    // fragment_index[70:65], fragment_length[86:71], zero fill [87]
    input  logic [87:0] s_tdata,
    // command[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // slot_out[9:0], timestamp[41:10], received_length[57:42], message_length[73:58],
    // zero fill [79:74]
    output logic [79:0] m_tdata,
    // status[2:0]
    output logic [2:0]  m_tuser
);
    import frt_pkg::*;

    cmd_req_t in_req;
    cmd_req_t q_req;
    logic     q_valid;
    logic     q_pop;
    result_t  res;

    always_comb
    begin
        in_req.command         = s_tuser;
        in_req.current_time    = s_tdata[31:0];
        in_req.slot            = s_tdata[41:32];
        in_req.total_length    = s_tdata[57:42];
        in_req.fragment_count  = s_tdata[64:58];
        in_req.fragment_index  = s_tdata[70:65];
        in_req.fragment_length = s_tdata[86:71];
        in_req.slot_ok         = 1'b0;
        in_req.count_ok        = 1'b0;
    end

    frt_front #(
        .SLOT_COUNT    (SLOT_COUNT),
        .MAX_FRAGMENTS (MAX_FRAGMENTS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_req   (in_req),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_req    (q_req)
    );

    frt_back #(
        .SLOT_COUNT    (SLOT_COUNT),
        .MAX_FRAGMENTS (MAX_FRAGMENTS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_req     (q_req),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tuser = res.status;
    assign m_tdata = {6'b0, res.message_length, res.received_length, res.timestamp,
                      res.slot_out};

endmodule
